>>> src/assert_macros.svh
// Assertion macros used by the port-level checker, rdcc_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RDCC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RDCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> src/rdcc_pkg.sv
// Shared types and constants for the damage rectangle clip and merge unit.
// No dependencies.
package rdcc_pkg;

	localparam int MAX_RECTS  = 64;
	localparam int CNT_W      = $clog2(MAX_RECTS + 1);
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	localparam logic [1:0] CFG_WINDOW_LEFT   = 2'd0;
	localparam logic [1:0] CFG_WINDOW_TOP    = 2'd1;
	localparam logic [1:0] CFG_WINDOW_WIDTH  = 2'd2;
	localparam logic [1:0] CFG_WINDOW_HEIGHT = 2'd3;

	typedef struct packed {
		logic signed [15:0] rect_left;
		logic signed [15:0] rect_top;
		logic [15:0]        rect_width;
		logic [15:0]        rect_height;
		logic               frame_end;
	} rect_item_t;

	typedef struct packed {
		logic signed [15:0] out_left;
		logic signed [15:0] out_top;
		logic [15:0]        out_width;
		logic [15:0]        out_height;
		logic               is_final;
		logic               is_empty;
	} result_item_t;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] top;
		logic [15:0]        width;
		logic [15:0]        height;
		logic signed [17:0] right;
		logic               hit;
		logic               frame_end;
	} clip_t;

	typedef struct packed {
		logic [1:0]   count;
		result_item_t first;
		result_item_t second;
	} push_t;

endpackage

>>> src/rdcc_clip.sv
// Clips one damage rectangle against the capture window (combinational).
// Depends on rdcc_pkg.
module rdcc_clip (
	input  rdcc_pkg::rect_item_t item,
	input  logic signed [15:0]   window_left,
	input  logic signed [15:0]   window_top,
	input  logic [15:0]          window_width,
	input  logic [15:0]          window_height,
	output rdcc_pkg::clip_t      clip
);
	import rdcc_pkg::*;

	logic signed [17:0] wl, wt, wr, wb, l, t, x2, y2, ix1, iy1, ix2, iy2, dx, dy;

	always_comb begin
		wl  = 18'(window_left);
		wt  = 18'(window_top);
		wr  = wl + $signed({2'b00, window_width});
		wb  = wt + $signed({2'b00, window_height});
		l   = 18'(item.rect_left);
		t   = 18'(item.rect_top);
		x2  = l + $signed({2'b00, item.rect_width});
		y2  = t + $signed({2'b00, item.rect_height});
		ix1 = (l < wl) ? wl : l;
		iy1 = (t < wt) ? wt : t;
		ix2 = (x2 > wr) ? wr : x2;
		iy2 = (y2 > wb) ? wb : y2;
		dx  = ix2 - ix1;
		dy  = iy2 - iy1;

		clip.left      = ix1[15:0];
		clip.top       = iy1[15:0];
		clip.width     = dx[15:0];
		clip.height    = dy[15:0];
		clip.right     = ix2;
		clip.hit       = (ix2 > ix1) && (iy2 > iy1);
		clip.frame_end = item.frame_end;
	end

endmodule

>>> src/rdcc_merge.sv
// Pending rectangle, horizontal merge and per-frame emit cap.
// Depends on rdcc_pkg.
module rdcc_merge (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  rdcc_pkg::clip_t clip,
	output rdcc_pkg::push_t push
);
	import rdcc_pkg::*;

	localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_RECTS);

	logic               pend_valid_q;
	logic signed [15:0] pend_left_q, pend_top_q;
	logic [15:0]        pend_width_q, pend_height_q;
	logic [CNT_W-1:0]   count_q;

	logic               touch, emit_mid;
	logic signed [17:0] pend_right, grown;
	logic               nx_valid;
	logic signed [15:0] nx_left, nx_top;
	logic [15:0]        nx_width, nx_height;
	logic [CNT_W-1:0]   nx_count;
	result_item_t       mid_res, fin_res;

	always_comb begin
		pend_right = 18'(pend_left_q) + $signed({2'b00, pend_width_q});
		grown      = clip.right - 18'(pend_left_q);
		touch      = pend_valid_q && (pend_top_q == clip.top) &&
			(pend_height_q == clip.height) && (pend_right == 18'(clip.left));
		emit_mid   = clip.hit && !touch && pend_valid_q && (count_q < CAP);

		nx_valid  = pend_valid_q;
		nx_left   = pend_left_q;
		nx_top    = pend_top_q;
		nx_width  = pend_width_q;
		nx_height = pend_height_q;
		nx_count  = count_q + CNT_W'(emit_mid);
		if (clip.hit) begin
			if (touch) begin
				nx_width = grown[15:0];
			end else begin
				nx_valid  = 1'b1;
				nx_left   = clip.left;
				nx_top    = clip.top;
				nx_width  = clip.width;
				nx_height = clip.height;
			end
		end

		mid_res = '{out_left: pend_left_q, out_top: pend_top_q, out_width: pend_width_q,
			out_height: pend_height_q, is_final: 1'b0, is_empty: 1'b0};
		if (nx_valid && (nx_count < CAP)) begin
			fin_res = '{out_left: nx_left, out_top: nx_top, out_width: nx_width,
				out_height: nx_height, is_final: 1'b1, is_empty: 1'b0};
		end else begin
			fin_res = '{out_left: '0, out_top: '0, out_width: '0,
				out_height: '0, is_final: 1'b1, is_empty: 1'b1};
		end

		push.count  = advance ? (2'(emit_mid) + 2'(clip.frame_end)) : 2'd0;
		push.first  = emit_mid ? mid_res : fin_res;
		push.second = fin_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q  <= 1'b0;
			pend_left_q   <= '0;
			pend_top_q    <= '0;
			pend_width_q  <= '0;
			pend_height_q <= '0;
			count_q       <= '0;
		end else if (advance) begin
			if (clip.frame_end) begin
				// frame closed: drop pending and restart the cap
				pend_valid_q  <= 1'b0;
				pend_left_q   <= '0;
				pend_top_q    <= '0;
				pend_width_q  <= '0;
				pend_height_q <= '0;
				count_q       <= '0;
			end else begin
				pend_valid_q  <= nx_valid;
				pend_left_q   <= nx_left;
				pend_top_q    <= nx_top;
				pend_width_q  <= nx_width;
				pend_height_q <= nx_height;
				count_q       <= nx_count;
			end
		end
	end

endmodule

>>> src/rdcc_out_fifo.sv
// Result queue: takes up to two results a cycle, hands out one unless result_stall holds it.
// Depends on rdcc_pkg.
module rdcc_out_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rdcc_pkg::push_t        push,
	output logic                   has_room,
	output logic                   result_valid,
	input  logic                   result_stall,
	output rdcc_pkg::result_item_t result
);
	import rdcc_pkg::*;

	result_item_t      mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  rd_ptr_q, wr_ptr_q, wr_ptr_nx;
	logic [FCNT_W-1:0] fill_q;
	logic              pop;

	assign result_valid = (fill_q != '0);
	assign result       = mem_q[rd_ptr_q];
	assign pop          = result_valid && !result_stall;
	// room for the worst case of two results from one transaction
	assign has_room     = (fill_q <= FCNT_W'(FIFO_DEPTH - 2));
	assign wr_ptr_nx    = wr_ptr_q + PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_nx] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.count);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			fill_q   <= fill_q + FCNT_W'(push.count) - FCNT_W'(pop);
		end
	end

endmodule

>>> src/damage_rect_clip_coalesce_unit.sv
// Top level of the damage rectangle clip and merge unit.
// Depends on rdcc_pkg, rdcc_clip, rdcc_merge and rdcc_out_fifo.
//
//  channel   handshake                payload
//  rect      rect_valid / rect_stall  rect (rect_item_t)
//  result    result_valid / result_stall  result (result_item_t)
//  cfg       cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One rectangle enters per cycle while the queue has room; it is clipped and merged
// while it sits in its input register, and its results land in a four-entry queue.
// An item with a mid-frame emit plus frame end gives two results; the single
// result port then sets the pace at one result per cycle unless result_stall holds it.
// An accepted rectangle passes its input register and then the result queue.
// arst_n clears window registers, pending rectangle, cap count and queue.
// rect_stall rises only when the queue lacks room for two more results.
module damage_rect_clip_coalesce_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rect_valid,
	output logic                   rect_stall,
	input  rdcc_pkg::rect_item_t   rect,
	output logic                   result_valid,
	input  logic                   result_stall,
	output rdcc_pkg::result_item_t result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [15:0]            cfg_data
);
	import rdcc_pkg::*;

	logic signed [15:0] win_left_q, win_top_q;
	logic [15:0]        win_width_q, win_height_q;
	rect_item_t         rect_s1;
	logic               valid_s1;
	logic               has_room, advance, accept;
	clip_t              clip;
	push_t              push;

	assign cfg_ready  = 1'b1;
	assign advance    = valid_s1 && has_room;
	assign rect_stall = valid_s1 && !has_room;
	assign accept     = rect_valid && !rect_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left_q   <= '0;
			win_top_q    <= '0;
			win_width_q  <= '0;
			win_height_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WINDOW_LEFT:   win_left_q   <= cfg_data;
				CFG_WINDOW_TOP:    win_top_q    <= cfg_data;
				CFG_WINDOW_WIDTH:  win_width_q  <= cfg_data;
				CFG_WINDOW_HEIGHT: win_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rect_s1 <= rect;
		end
	end

	rdcc_clip u_clip (
		.item          (rect_s1),
		.window_left   (win_left_q),
		.window_top    (win_top_q),
		.window_width  (win_width_q),
		.window_height (win_height_q),
		.clip          (clip)
	);

	rdcc_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.clip    (clip),
		.push    (push)
	);

	rdcc_out_fifo u_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.has_room     (has_room),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

>>> src/rdcc_checker.sv
// Port-level checks for the damage rectangle clip and merge unit, bound to the top.
// Depends on rdcc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rdcc_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   rect_stall,
	input logic                   result_valid,
	input logic                   result_stall,
	input rdcc_pkg::result_item_t result
);
	import rdcc_pkg::*;

	// a stalled result transaction holds
	`RDCC_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result))
	// the end marker is always final and carries a zero rectangle
	`RDCC_ASSERT_SAME(a_empty_final, clk, arst_n, result_valid && result.is_empty, result.is_final && result.out_width == 16'd0 && result.out_height == 16'd0)
	// a real rectangle never has zero height
	`RDCC_ASSERT_SAME(a_rect_height, clk, arst_n, result_valid && !result.is_empty, result.out_height != 16'd0)
	// input backpressure only comes from queued results
	`RDCC_ASSERT_SAME(a_stall_cause, clk, arst_n, rect_stall, result_valid)

endmodule

bind damage_rect_clip_coalesce_unit rdcc_checker u_rdcc_checker (.*);

>>> dv/rdcc_result_checker.sv
`timescale 1ns / 100ps
// Result checker for damage_rect_clip_coalesce_unit: follows the rect, result and cfg
// channels, predicts each result from the accepted rectangles and compares it.
// Depends on rdcc_pkg.
module rdcc_result_checker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rect_valid,
	input  logic                   rect_stall,
	input  rdcc_pkg::rect_item_t   rect,
	input  logic                   result_valid,
	input  logic                   result_stall,
	input  rdcc_pkg::result_item_t result,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [15:0]            cfg_data,
	output int                     err_count,
	output int                     outstanding,
	output int                     checked_count
);
	import rdcc_pkg::*;

	// window registers as the block should hold them
	logic signed [15:0] win_left;
	logic signed [15:0] win_top;
	logic [15:0]        win_width;
	logic [15:0]        win_height;

	// rectangle still open for widening
	logic               pend_valid;
	logic signed [15:0] pend_left;
	logic signed [15:0] pend_top;
	logic [15:0]        pend_width;
	logic [15:0]        pend_height;
	logic [6:0]         frame_emits;

	result_item_t due_results[$];

	function automatic result_item_t pending_result(input logic fin);
		result_item_t r;
		r.out_left   = pend_left;
		r.out_top    = pend_top;
		r.out_width  = pend_width;
		r.out_height = pend_height;
		r.is_final   = fin;
		r.is_empty   = 1'b0;
		return r;
	endfunction

	task automatic clip_and_merge(input rect_item_t it);
		logic signed [17:0] wl, wt, wr, wb;
		logic signed [17:0] x1, y1, x2, y2;
		logic signed [17:0] cx1, cy1, cx2, cy2, p_right;
		logic [15:0]        nh;
		result_item_t       marker;
		wl = $signed(win_left);
		wt = $signed(win_top);
		wr = wl + $signed({2'b00, win_width});
		wb = wt + $signed({2'b00, win_height});
		x1 = $signed(it.rect_left);
		y1 = $signed(it.rect_top);
		x2 = x1 + $signed({2'b00, it.rect_width});
		y2 = y1 + $signed({2'b00, it.rect_height});
		cx1 = (x1 < wl) ? wl : x1;
		cy1 = (y1 < wt) ? wt : y1;
		cx2 = (x2 > wr) ? wr : x2;
		cy2 = (y2 > wb) ? wb : y2;

		if (cx2 > cx1 && cy2 > cy1) begin
			nh = 16'(cy2 - cy1);
			// full right edge, no 16-bit wrap
			p_right = $signed(pend_left) + $signed({2'b00, pend_width});
			if (pend_valid && $signed(pend_top) == cy1 && pend_height == nh &&
					p_right == cx1) begin
				pend_width = 16'(cx2 - $signed(pend_left));
			end else begin
				if (pend_valid && frame_emits < MAX_RECTS) begin
					due_results.push_back(pending_result(1'b0));
					frame_emits++;
				end
				pend_valid  = 1'b1;
				pend_left   = cx1[15:0];
				pend_top    = cy1[15:0];
				pend_width  = 16'(cx2 - cx1);
				pend_height = nh;
			end
		end

		if (it.frame_end) begin
			if (pend_valid && frame_emits < MAX_RECTS) begin
				due_results.push_back(pending_result(1'b1));
			end else begin
				marker = '0;
				marker.is_final = 1'b1;
				marker.is_empty = 1'b1;
				due_results.push_back(marker);
			end
			pend_valid  = 1'b0;
			pend_left   = '0;
			pend_top    = '0;
			pend_width  = '0;
			pend_height = '0;
			frame_emits = '0;
		end
	endtask

	task automatic check_result(input result_item_t got);
		result_item_t want;
		if (due_results.size() == 0) begin
			err_count++;
			if (err_count <= 10)
				$display("%0t: result with none due: l=%0d t=%0d w=%0d h=%0d f=%0b e=%0b",
					$realtime, got.out_left, got.out_top, got.out_width, got.out_height,
					got.is_final, got.is_empty);
			return;
		end
		want = due_results.pop_front();
		checked_count++;
		if (got.out_left !== want.out_left || got.out_top !== want.out_top ||
				got.out_width !== want.out_width || got.out_height !== want.out_height ||
				got.is_final !== want.is_final || got.is_empty !== want.is_empty) begin
			err_count++;
			if (err_count <= 10)
				$display("%0t: mismatch: want l=%0d t=%0d w=%0d h=%0d f=%0b e=%0b, %s%0d %0d %0d %0d %0b %0b",
					$realtime, want.out_left, want.out_top, want.out_width,
					want.out_height, want.is_final, want.is_empty, "got ",
					got.out_left, got.out_top, got.out_width, got.out_height,
					got.is_final, got.is_empty);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left      = '0;
			win_top       = '0;
			win_width     = '0;
			win_height    = '0;
			pend_valid    = 1'b0;
			pend_left     = '0;
			pend_top      = '0;
			pend_width    = '0;
			pend_height   = '0;
			frame_emits   = '0;
			err_count     = 0;
			checked_count = 0;
			due_results.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_WINDOW_LEFT:   win_left   = cfg_data;
					CFG_WINDOW_TOP:    win_top    = cfg_data;
					CFG_WINDOW_WIDTH:  win_width  = cfg_data;
					CFG_WINDOW_HEIGHT: win_height = cfg_data;
					default: ;
				endcase
			end
			if (rect_valid && !rect_stall)
				clip_and_merge(rect);
			if (result_valid && !result_stall)
				check_result(result);
			outstanding <= due_results.size();
		end
	end

endmodule

>>> dv/damage_rect_clip_coalesce_unit_test.sv
`timescale 1ns / 100ps
// Testbench top for damage_rect_clip_coalesce_unit: drives rectangles, window writes and
// result back-pressure, and gives the verdict from rdcc_result_checker's counts.
// Depends on rdcc_pkg, rdcc_result_checker and the block itself.
module damage_rect_clip_coalesce_unit_test;
	import rdcc_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 6;

	logic         clk;
	logic         arst_n;
	logic         rect_valid;
	logic         rect_stall;
	rect_item_t   rect;
	logic         result_valid;
	logic         result_stall;
	result_item_t result;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [15:0]  cfg_data;

	int err_count;
	int outstanding;
	int checked_count;

	int snd_idle;
	int rcv_idle;
	int hold_req;
	int sent_items;
	int frames_sent;
	int cycles;
	int cur_wl, cur_wt, cur_ww, cur_wh;

	damage_rect_clip_coalesce_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.rect_valid   (rect_valid),
		.rect_stall   (rect_stall),
		.rect         (rect),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	rdcc_result_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.rect_valid    (rect_valid),
		.rect_stall    (rect_stall),
		.rect          (rect),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.err_count     (err_count),
		.outstanding   (outstanding),
		.checked_count (checked_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("damage_rect_clip_coalesce_unit verification failed");
		$finish;
	end

	// result side: random stall, or a long hold-off when one is requested
	initial begin : receiver
		int hold_cnt;
		hold_cnt = 0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_cnt = hold_req;
				hold_req = 0;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(0, 99) < rcv_idle);
			end
		end
	end

	function automatic rect_item_t make_rect(input int l, input int t, input int w,
			input int h, input bit fe);
		rect_item_t r;
		r.rect_left   = 16'(l);
		r.rect_top    = 16'(t);
		r.rect_width  = 16'(w);
		r.rect_height = 16'(h);
		r.frame_end   = fe;
		return r;
	endfunction

	// hold the rectangle until the transaction completes
	task automatic send_rect(input rect_item_t it);
		while ($urandom_range(0, 99) < snd_idle) begin
			rect_valid <= 1'b0;
			@(posedge clk);
		end
		rect_valid <= 1'b1;
		rect       <= it;
		do @(posedge clk); while (rect_stall);
		sent_items++;
		if (it.frame_end)
			frames_sent++;
	endtask

	// drop valid and wait until every due result has come back
	task automatic drain_results();
		rect_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_window(input int l, input int t, input int w, input int h);
		cur_wl = l;
		cur_wt = t;
		cur_ww = w;
		cur_wh = h;
		write_reg(CFG_WINDOW_LEFT, 16'(l));
		write_reg(CFG_WINDOW_TOP, 16'(t));
		write_reg(CFG_WINDOW_WIDTH, 16'(w));
		write_reg(CFG_WINDOW_HEIGHT, 16'(h));
		cfg_valid <= 1'b0;
	endtask

	// one frame of rectangles around the window; chains add touching runs
	task automatic send_frame(input int len, input bit chains);
		int k, sel, l, t, w, h, pl, pt, pw, ph, span_x, span_y;
		pl = cur_wl;
		pt = cur_wt;
		pw = 0;
		ph = 0;
		span_x = (cur_ww < 400) ? cur_ww : 400;
		span_y = (cur_wh < 400) ? cur_wh : 400;
		for (k = 0; k < len; k++) begin
			sel = $urandom_range(0, 99);
			if (sel < 15) begin
				l = $urandom_range(0, 65535) - 32768;
				t = $urandom_range(0, 65535) - 32768;
				w = $urandom_range(0, 65535);
				h = $urandom_range(0, 65535);
			end else if (chains && k > 0 && sel < 60) begin
				// touch the previous one, or miss it by a pixel
				l = pl + pw + ((sel < 52) ? 0 : 1);
				t = pt;
				h = ph;
				w = $urandom_range(0, 50);
			end else begin
				l = cur_wl - 20 + $urandom_range(0, span_x + 40);
				t = cur_wt - 20 + $urandom_range(0, span_y + 40);
				w = $urandom_range(0, 60);
				h = $urandom_range(0, 40);
			end
			pl = l;
			pt = t;
			pw = w;
			ph = h;
			send_rect(make_rect(l, t, w, h, k == len - 1));
		end
	endtask

	initial begin
		int phase, seg, seg_items, n;
		arst_n      = 1'b0;
		rect_valid  = 1'b0;
		rect        = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		snd_idle    = 14;
		rcv_idle    = 67;
		hold_req    = 0;
		sent_items  = 0;
		frames_sent = 0;
		cur_wl = 0;
		cur_wt = 0;
		cur_ww = 0;
		cur_wh = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// window still empty from reset: only the end marker comes out
		send_rect(make_rect(0, 0, 10, 10, 0));
		send_rect(make_rect(5, 5, 3, 3, 1));
		drain_results();

		set_window(-100, -50, 400, 300);
		send_rect(make_rect(-32768, -32768, 65535, 65535, 0));
		send_rect(make_rect(300, -50, 10, 300, 0));
		send_rect(make_rect(0, 0, 0, 50, 0));
		send_rect(make_rect(32767, 32767, 65535, 65535, 1));
		// touching run, then a new top, then a new height
		send_rect(make_rect(10, 20, 30, 40, 0));
		send_rect(make_rect(40, 20, 15, 40, 0));
		send_rect(make_rect(55, 20, 5, 40, 0));
		send_rect(make_rect(60, 21, 5, 40, 0));
		send_rect(make_rect(65, 21, 5, 39, 1));
		send_rect(make_rect(0, 0, 0, 0, 1));
		send_rect(make_rect(-200, -100, 150, 100, 0));
		send_rect(make_rect(-50, -50, 65535, 50, 1));
		send_rect(make_rect(1000, 0, 5, 5, 1));
		drain_results();

		// merged right edge past the 16-bit range, then its wrapped alias
		set_window(-31000, 0, 65535, 100);
		send_rect(make_rect(32000, 0, 767, 10, 0));
		send_rect(make_rect(32767, 0, 1000, 10, 0));
		send_rect(make_rect(-31769, 0, 100, 10, 1));
		send_rect(make_rect(0, 0, 10, 10, 0));
		drain_results();

		// window change with a rectangle still pending
		set_window(0, 0, 65535, 65535);
		send_rect(make_rect(10, 0, 10, 10, 1));

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					snd_idle = 14;
					rcv_idle = 67;
				end
				1: begin
					snd_idle = 67;
					rcv_idle = 14;
				end
				default: begin
					snd_idle = 0;
					rcv_idle = 0;
				end
			endcase
			for (seg = 0; seg < 4; seg++) begin
				drain_results();
				if (seg < 2) begin
					set_window($urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
						$urandom_range(100, 400), $urandom_range(100, 300));
				end else if (seg == 3) begin
					set_window($urandom_range(0, 65535) - 32768,
						$urandom_range(0, 65535) - 32768,
						$urandom_range(0, 65535), $urandom_range(0, 65535));
				end else if (phase == 0) begin
					set_window(-32768, -32768, 65535, 65535);
				end else if (phase == 1) begin
					set_window(32767, 32767, 65535, 65535);
				end else if ($urandom_range(0, 1) == 0) begin
					set_window($urandom_range(0, 200) - 100, 0, 0, $urandom_range(1, 300));
				end else begin
					set_window(0, $urandom_range(0, 200) - 100, $urandom_range(1, 300), 0);
				end

				// stall results for a long stretch while rectangles keep coming
				if (phase == 2 && seg == 0)
					hold_req = 300;

				seg_items = 0;
				if (seg == 1) begin
					// enough separate rectangles to pass the per-frame cap
					n = $urandom_range(110, 130);
					send_frame(n, 1'b0);
					seg_items += n;
				end
				while (seg_items < 100) begin
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
						: $urandom_range(1, 6);
					send_frame(n, 1'b1);
					seg_items += n;
				end
			end
		end

		drain_results();
		$display("sent %0d rectangles in %0d frames over empty, small, full-range and random windows",
			sent_items, frames_sent);
		$display("checked %0d results under mixed, reversed and no back-pressure; %0d errors",
			checked_count, err_count);
		if (err_count == 0 && outstanding == 0) begin
			$display("damage_rect_clip_coalesce_unit verification clean");
		end else begin
			$display("damage_rect_clip_coalesce_unit verification failed");
		end
		$finish;
	end

endmodule
